// ===== sv/clp_pkg.sv =====
// Shared types and constants of the closed polygon perimeter block.
`default_nettype none

package clp_pkg;

  // Width of the disc radius register (unsigned fixed point).
  localparam int RADIUS_WIDTH = 24;

  // Two pi in Q.32, split into two partial products for the shared multiplier.
  localparam int TWO_PI_WIDTH   = 35;
  localparam logic [TWO_PI_WIDTH-1:0] TWO_PI_Q32 = 35'h6487ED511;
  localparam int TWO_PI_LO_BITS = 18;
  localparam int CIRC_FRAC      = 32;
  localparam int CIRC_ACC_WIDTH = RADIUS_WIDTH + TWO_PI_WIDTH;
  localparam int CIRC_WIDTH     = CIRC_ACC_WIDTH - CIRC_FRAC;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQSUM,
    ST_ROOT,
    ST_ACC,
    ST_CIRC_LO,
    ST_CIRC_HI,
    ST_CIRC_ADD,
    ST_ROUND,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== sv/clp_mul.sv =====
// Registered unsigned multiplier shared by the squaring and circle steps.
`default_nettype none

module clp_mul #(
  parameter int WIDTH = 25
) (
  input  wire logic                 clk,
  input  wire logic [WIDTH-1:0]     a,
  input  wire logic [WIDTH-1:0]     b,
  output logic      [2*WIDTH-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// ===== sv/clp_isqrt.sv =====
// Restoring integer square root, one result bit per clock cycle.
`default_nettype none

module clp_isqrt #(
  parameter int ROOT_W = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done_r,
  output logic      [ROOT_W-1:0]     root_r
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] rem_r;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W+1:0] rem_sub;
  logic              ge;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below 2^ROOT_W until the last step, whose
  // remainder is not needed.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== sv/closed_polygon_perimeter.sv =====
// Top level of the closed polygon perimeter block with a swept disc.
// Usage:
//   Vertices arrive one per request on the in_ channel (valid/ready) as
//   signed fixed-point coordinates; in_final_vertex marks the last vertex
//   of a polygon. Each vertex after the first adds the Euclidean length of
//   the edge from the previous vertex to a saturating running sum. The
//   final vertex also adds the closing edge and two pi times the disc
//   radius, and the total leaves as one request on the out_ channel. The
//   user writes the disc radius via cfg_we / cfg_wdata while idle (unenforced).
// Flow:
//   in_ready is high only while the block is idle. A vertex that opens a
//   polygon only stores its coordinates, so in_ready stays high unless it
//   is also final. Any other vertex holds in_ready low while its edge is
//   squared on the shared multiplier, rooted by the 25-step square root on
//   one compare-and-subtract unit and accumulated. A final vertex then does
//   the same for the closing edge, adds the circle term and hands over.
// Reset and stalls:
//   A synchronous active-low reset clears the polygon, the radius and out_valid.
//   The result waits in an output register, so a new polygon may start while
//   out_ready is low; only a second finished result waits for the first.
`default_nettype none

module closed_polygon_perimeter #(
  parameter int COORD_WIDTH = 24,
  parameter int SUM_WIDTH   = 40
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration port: disc radius
  input  wire logic                                cfg_we,
  input  wire logic [clp_pkg::RADIUS_WIDTH-1:0]    cfg_wdata,
  // Vertex requests
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       in_x_coord,
  input  wire logic signed [COORD_WIDTH-1:0]       in_y_coord,
  input  wire logic                                in_final_vertex,
  // Perimeter results
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [SUM_WIDTH-1:0]                     out_perimeter
);

  // A coordinate difference needs one bit more than a coordinate; its
  // magnitude is at most 2^COORD_WIDTH and so fits unsigned in DIFF_W bits.
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int ROOT_W  = DIFF_W;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int MUL_W   = (DIFF_W > clp_pkg::RADIUS_WIDTH) ? DIFF_W : clp_pkg::RADIUS_WIDTH;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ADD_W0  = (SUM_WIDTH > ROOT_W) ? SUM_WIDTH : ROOT_W;
  localparam int ADD_W   = (ADD_W0 > clp_pkg::CIRC_WIDTH) ? ADD_W0 : clp_pkg::CIRC_WIDTH;
  localparam int CACC_W  = clp_pkg::CIRC_ACC_WIDTH;
  localparam int HI_BITS = clp_pkg::TWO_PI_WIDTH - clp_pkg::TWO_PI_LO_BITS;
  localparam int LO_BITS = clp_pkg::TWO_PI_LO_BITS;

  localparam logic [HI_BITS-1:0] TWO_PI_HI =
    clp_pkg::TWO_PI_Q32[clp_pkg::TWO_PI_WIDTH-1:LO_BITS];
  localparam logic [LO_BITS-1:0] TWO_PI_LO = clp_pkg::TWO_PI_Q32[LO_BITS-1:0];
  localparam logic [CACC_W-1:0] CIRC_HALF = CACC_W'(1) << (clp_pkg::CIRC_FRAC - 1);
  localparam logic [ADD_W:0] SUM_LIM = (ADD_W + 1)'({SUM_WIDTH{1'b1}});

  // Control state
  clp_pkg::state_t state_r, state_nxt;
  logic                 have_first_r, have_first_nxt;
  logic                 closing_r, closing_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic [clp_pkg::RADIUS_WIDTH-1:0] radius_r, radius_nxt;

  // Payload state
  logic signed [COORD_WIDTH-1:0] first_x_r, first_x_nxt;
  logic signed [COORD_WIDTH-1:0] first_y_r, first_y_nxt;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_x_nxt;
  logic signed [COORD_WIDTH-1:0] prev_y_r, prev_y_nxt;
  logic                          last_r, last_nxt;
  logic [DIFF_W-1:0]             ux_r, ux_nxt;
  logic [DIFF_W-1:0]             uy_r, uy_nxt;
  logic [RAD_W-1:0]              rad_r, rad_nxt;
  logic [CACC_W-1:0]             circ_r, circ_nxt;
  logic [SUM_WIDTH-1:0]          out_r, out_nxt;

  // Shared units
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic              sq_start;
  logic [RAD_W-1:0]  sq_radicand;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  // Edge difference datapath: one subtractor pair serves both the edge
  // from the previous vertex (on accept) and the closing edge.
  logic signed [COORD_WIDTH-1:0] dif_ax, dif_bx, dif_ay, dif_by;
  logic [DIFF_W-1:0]             dx, dy, mag_x, mag_y;

  // Saturating accumulator adder, shared by edge and circle terms.
  logic [ADD_W-1:0]     add_b;
  logic [ADD_W:0]       add_full;
  logic [SUM_WIDTH-1:0] add_sat;

  clp_mul #(
    .WIDTH (MUL_W)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  clp_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_radicand),
    .done_r   (sq_done),
    .root_r   (sq_root)
  );

  always_comb begin
    if (state_r == clp_pkg::ST_IDLE) begin
      dif_ax = in_x_coord;
      dif_ay = in_y_coord;
      dif_bx = prev_x_r;
      dif_by = prev_y_r;
    end else begin
      dif_ax = prev_x_r;
      dif_ay = prev_y_r;
      dif_bx = first_x_r;
      dif_by = first_y_r;
    end
    dx    = {dif_ax[COORD_WIDTH-1], dif_ax} - {dif_bx[COORD_WIDTH-1], dif_bx};
    dy    = {dif_ay[COORD_WIDTH-1], dif_ay} - {dif_by[COORD_WIDTH-1], dif_by};
    mag_x = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
    mag_y = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
  end

  always_comb begin
    if (state_r == clp_pkg::ST_ROUND) begin
      add_b = ADD_W'(circ_r[CACC_W-1 -: clp_pkg::CIRC_WIDTH]);
    end else begin
      add_b = ADD_W'(sq_root);
    end
    add_full = (ADD_W + 1)'(sum_r) + (ADD_W + 1)'(add_b);
    add_sat  = (add_full > SUM_LIM) ? {SUM_WIDTH{1'b1}} : add_full[SUM_WIDTH-1:0];
  end

  assign sq_radicand = rad_r + RAD_W'(prod_r);

  // Sequencer: next state, register updates and unit controls.
  always_comb begin
    state_nxt      = state_r;
    have_first_nxt = have_first_r;
    closing_nxt    = closing_r;
    sum_nxt        = sum_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    last_nxt       = last_r;
    ux_nxt         = ux_r;
    uy_nxt         = uy_r;
    rad_nxt        = rad_r;
    circ_nxt       = circ_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    radius_nxt     = cfg_we ? cfg_wdata : radius_r;
    mul_a          = '0;
    mul_b          = '0;
    sq_start       = 1'b0;

    unique case (state_r)
      clp_pkg::ST_IDLE: begin
        if (in_valid) begin
          last_nxt   = in_final_vertex;
          prev_x_nxt = in_x_coord;
          prev_y_nxt = in_y_coord;
          if (!have_first_r) begin
            first_x_nxt    = in_x_coord;
            first_y_nxt    = in_y_coord;
            have_first_nxt = 1'b1;
            sum_nxt        = '0;
            // A lone vertex has a closing edge of zero length.
            state_nxt      = in_final_vertex ? clp_pkg::ST_CIRC_LO : clp_pkg::ST_IDLE;
          end else begin
            ux_nxt      = mag_x;
            uy_nxt      = mag_y;
            closing_nxt = 1'b0;
            state_nxt   = clp_pkg::ST_SQX;
          end
        end
      end
      clp_pkg::ST_SQX: begin
        mul_a     = MUL_W'(ux_r);
        mul_b     = MUL_W'(ux_r);
        state_nxt = clp_pkg::ST_SQY;
      end
      clp_pkg::ST_SQY: begin
        mul_a     = MUL_W'(uy_r);
        mul_b     = MUL_W'(uy_r);
        rad_nxt   = RAD_W'(prod_r);
        state_nxt = clp_pkg::ST_SQSUM;
      end
      clp_pkg::ST_SQSUM: begin
        sq_start  = 1'b1;
        state_nxt = clp_pkg::ST_ROOT;
      end
      clp_pkg::ST_ROOT: begin
        if (sq_done) begin
          state_nxt = clp_pkg::ST_ACC;
        end
      end
      clp_pkg::ST_ACC: begin
        sum_nxt = add_sat;
        if (closing_r) begin
          state_nxt = clp_pkg::ST_CIRC_LO;
        end else if (last_r) begin
          ux_nxt      = mag_x;
          uy_nxt      = mag_y;
          closing_nxt = 1'b1;
          state_nxt   = clp_pkg::ST_SQX;
        end else begin
          state_nxt = clp_pkg::ST_IDLE;
        end
      end
      clp_pkg::ST_CIRC_LO: begin
        mul_a     = MUL_W'(radius_r);
        mul_b     = MUL_W'(TWO_PI_LO);
        state_nxt = clp_pkg::ST_CIRC_HI;
      end
      clp_pkg::ST_CIRC_HI: begin
        mul_a     = MUL_W'(radius_r);
        mul_b     = MUL_W'(TWO_PI_HI);
        circ_nxt  = CACC_W'(prod_r);
        state_nxt = clp_pkg::ST_CIRC_ADD;
      end
      clp_pkg::ST_CIRC_ADD: begin
        // Upper partial product plus the rounding half of the Q.32 scale.
        circ_nxt  = circ_r + (CACC_W'(prod_r) << LO_BITS) + CIRC_HALF;
        state_nxt = clp_pkg::ST_ROUND;
      end
      clp_pkg::ST_ROUND: begin
        sum_nxt   = add_sat;
        state_nxt = clp_pkg::ST_FIN;
      end
      clp_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt        = sum_r;
          out_valid_nxt  = 1'b1;
          have_first_nxt = 1'b0;
          closing_nxt    = 1'b0;
          sum_nxt        = '0;
          state_nxt      = clp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= clp_pkg::ST_IDLE;
      have_first_r <= 1'b0;
      closing_r    <= 1'b0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      radius_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      have_first_r <= have_first_nxt;
      closing_r    <= closing_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
      radius_r     <= radius_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    last_r    <= last_nxt;
    ux_r      <= ux_nxt;
    uy_r      <= uy_nxt;
    rad_r     <= rad_nxt;
    circ_r    <= circ_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready      = (state_r == clp_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_perimeter = out_r;

`ifndef SYNTHESIS
  // The root unit only finishes while the sequencer waits for it.
  a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == clp_pkg::ST_ROOT))
    else $error("square root finished outside the wait state");

  // A result is only ever loaded from the hand-over state.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == clp_pkg::ST_FIN))
    else $error("result loaded outside the hand-over state");

  // With no polygon open the running sum is cleared.
  a_sum_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == clp_pkg::ST_IDLE) && !have_first_r) |-> (sum_r == '0))
    else $error("running sum not cleared between polygons");

  // The closing edge is only worked on for a final vertex.
  a_closing_final: assert property (@(posedge clk) disable iff (!rst_n)
    closing_r |-> last_r)
    else $error("closing edge started for a vertex that is not final");
`endif

endmodule

`default_nettype wire

// ===== verif/closed_polygon_perimeter_checker.sv =====
// Checker for the closed polygon perimeter block: predicts every perimeter and compares it.
`timescale 1ns / 100ps

module closed_polygon_perimeter_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [clp_pkg::RADIUS_WIDTH-1:0] cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [23:0]               in_x_coord,
  input  logic signed [23:0]               in_y_coord,
  input  logic                             in_final_vertex,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [39:0]                      out_perimeter,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int COORD_W = 24;
  localparam int SUM_W   = 40;
  localparam logic [63:0] TWO_PI_Q32_REF = 64'h6_487E_D511;

  logic signed [COORD_W-1:0]         start_x, start_y, last_x, last_y;
  logic [SUM_W-1:0]                  edge_total;
  logic                              polygon_open;
  logic [clp_pkg::RADIUS_WIDTH-1:0]  disc_radius;
  logic [SUM_W-1:0]                  perimeter_due[$];
  logic [SUM_W-1:0]                  wanted;

  task automatic flag(input string what, input logic [SUM_W-1:0] got,
                      input logic [SUM_W-1:0] want);
    if (mismatches < 32)
      $display("%0t ns perimeter checker: %s: got %0d, expected %0d",
               $time, what, got, want);
    mismatches++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned acc, probe, rem;
    acc = 0;
    rem = v;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  function automatic logic [SUM_W-1:0] edge_span(input logic signed [COORD_W-1:0] ax,
                                                  input logic signed [COORD_W-1:0] ay,
                                                  input logic signed [COORD_W-1:0] bx,
                                                  input logic signed [COORD_W-1:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return SUM_W'(root_floor(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic logic [SUM_W-1:0] sum_clamped(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  task automatic clear_polygon();
    start_x = '0;
    start_y = '0;
    last_x = '0;
    last_y = '0;
    edge_total = '0;
    polygon_open = 1'b0;
  endtask

  // Advances the polygon by one vertex and queues a perimeter when it closes.
  task automatic take_vertex(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input logic fin);
    logic [63:0]      circle;
    logic [SUM_W-1:0] total;
    if (!polygon_open) begin
      start_x = x;
      start_y = y;
      edge_total = '0;
      polygon_open = 1'b1;
    end else begin
      edge_total = sum_clamped(edge_total, edge_span(x, y, last_x, last_y));
    end
    last_x = x;
    last_y = y;
    if (fin) begin
      circle = (64'(disc_radius) * TWO_PI_Q32_REF + 64'h8000_0000) >> 32;
      total = sum_clamped(edge_total, edge_span(x, y, start_x, start_y));
      total = sum_clamped(total, SUM_W'(circle));
      perimeter_due.push_back(total);
      clear_polygon();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_polygon();
      disc_radius = '0;
      perimeter_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (perimeter_due.size() == 0) begin
          flag("perimeter with no polygon closed", out_perimeter, '0);
        end else begin
          wanted = perimeter_due.pop_front();
          if (out_perimeter !== wanted) flag("perimeter", out_perimeter, wanted);
        end
      end
      if (cfg_we) disc_radius = cfg_wdata;
      if (in_valid && in_ready) take_vertex(in_x_coord, in_y_coord, in_final_vertex);
    end
    outstanding <= perimeter_due.size();
  end

endmodule

// ===== verif/closed_polygon_perimeter_tb.sv =====
// Testbench top for the closed polygon perimeter block: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module closed_polygon_perimeter_tb;

  // Coordinate extremes of the 24-bit two's complement vertex fields.
  localparam logic signed [23:0] C_MIN = 24'sh80_0000;
  localparam logic signed [23:0] C_MAX = 24'sh7F_FFFF;
  // The longest request is a final vertex, which works through its own edge,
  // the closing edge and the circle term; settling waits comfortably beyond that.
  localparam int SETTLE_CYCLES = 100;
  // A correct run of about a thousand requests ends well before this
  // limit, even with the longest gaps and stalls.
  localparam int CYCLE_LIMIT = 4_000_000;
  // A long outline of maximal diagonal edges, to build up a large sum.
  localparam int LONG_OUTLINE_VERTICES = 64;
  localparam int RANDOM_PHASES = 6;
  localparam int REQUESTS_PER_PHASE = 135;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [23:0] in_x_coord = '0;
  logic signed [23:0] in_y_coord = '0;
  logic        in_final_vertex = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_perimeter;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;

  // Idling controls: the sender's gaps are used only by the stimulus process,
  // the receiver's stalls by the ready generator below.
  logic        tx_gaps = 1'b0;
  logic        rx_stalls = 1'b0;
  int unsigned stall_left = 0;

  int          phase_idx;
  int          sent;
  int          vertex_idx;
  logic [23:0] phase_radius;

  always #2 clk = ~clk;

  closed_polygon_perimeter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_final_vertex (in_final_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_perimeter   (out_perimeter)
  );

  closed_polygon_perimeter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_final_vertex (in_final_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_perimeter   (out_perimeter),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Gap lengths: mostly none or short, now and then a long one, so that the
  // idle cycles land on every stage of the square root and the circle term.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 70);
  endfunction

  // Coordinates in several flavours: the whole field, small values near the
  // origin, values of moderate size and the very edges of the range mixed with zero, minus one and random values.
  function automatic logic signed [23:0] pick_coord(input int unsigned flavour);
    int unsigned r;
    case (flavour)
      0: begin
        return 24'($urandom);
      end
      1: begin
        return 24'($urandom_range(0, 4095)) - 24'sd2048;
      end
      2: begin
        return 24'($urandom_range(0, 131071)) - 24'sd65536;
      end
      default: begin
        r = $urandom_range(0, 5);
        if (r == 0) return C_MIN;
        if (r == 1) return C_MAX;
        if (r == 2) return 24'sd0;
        if (r == 3) return -24'sd1;
        return 24'($urandom);
      end
    endcase
  endfunction

  // The receiver is always ready unless stalls are enabled, in which case it
  // drops ready for random stretches, mostly short ones.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // A hung handshake or a result that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("closed_polygon_perimeter_tb: FAIL");
      $finish;
    end
  end

  // Presents one vertex request and returns at the edge that accepts it. Any
  // gap comes first, with the payload scrambled while valid is low, so that a
  // valid that stays high is never lowered and raised within one step.
  task automatic push_vertex(input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic fin);
    int unsigned gap;
    gap = tx_gaps ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_x_coord <= 24'($urandom);
      in_y_coord <= 24'($urandom);
      in_final_vertex <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_x_coord <= x;
    in_y_coord <= y;
    in_final_vertex <= fin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender back until every expected perimeter has been taken, then
  // lets the block's own latency pass so that it is truly idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [23:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One polygon of random size and content. Most polygons are small; a few
  // are single vertices and a few run to a couple of dozen vertices.
  task automatic random_polygon(inout int count);
    int unsigned r, n, flavour;
    r = $urandom_range(0, 99);
    if (r < 10) n = 1;
    else if (r < 80) n = $urandom_range(2, 6);
    else if (r < 95) n = $urandom_range(7, 12);
    else n = $urandom_range(13, 24);
    flavour = $urandom_range(0, 3);
    for (int unsigned k = 0; k < n; k++) begin
      push_vertex(pick_coord(flavour), pick_coord(flavour), k == n - 1);
      count++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with the radius still at its reset value of zero:
    // a lone vertex at the top corner, a triangle spanning the full range, a
    // 3-4-5 two-vertex polygon and a polygon whose edges have zero length.
    push_vertex(C_MAX, C_MAX, 1'b1);
    push_vertex(C_MIN, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MAX, 1'b1);
    push_vertex(24'sd0, 24'sd0, 1'b0);
    push_vertex(24'sd768, 24'sd1024, 1'b1);
    push_vertex(24'sd5, -24'sd5, 1'b0);
    push_vertex(24'sd5, -24'sd5, 1'b1);
    drain();

    // The largest radius: a lone vertex yields the circle term alone, and a
    // square of mixed signs adds the lengths of its sides to it.
    write_radius(24'hFF_FFFF);
    push_vertex(C_MIN, 24'sd0, 1'b1);
    push_vertex(-24'sd256, -24'sd256, 1'b0);
    push_vertex(24'sd256, -24'sd256, 1'b0);
    push_vertex(24'sd256, 24'sd256, 1'b0);
    push_vertex(-24'sd256, 24'sd256, 1'b1);
    drain();

    // The smallest non-zero radius, where rounding of the circle term counts.
    write_radius(24'h00_0001);
    push_vertex(-24'sd1, 24'sd1, 1'b1);
    push_vertex(24'sd1, 24'sd0, 1'b0);
    push_vertex(24'sd0, 24'sd1, 1'b1);
    drain();

    // Random phases, each with its own radius and idling pattern. One phase
    // runs with no idling at all; another is followed by a long outline of
    // the longest possible edges.
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      case (phase_idx)
        1: phase_radius = 24'h00_0000;
        2: phase_radius = 24'hFF_FFFF;
        3: phase_radius = 24'($urandom_range(1, 255));
        4: phase_radius = 24'h80_0000;
        default: phase_radius = 24'($urandom);
      endcase
      write_radius(phase_radius);
      tx_gaps = (phase_idx != 2) && (phase_idx != 3);
      rx_stalls <= (phase_idx != 1) && (phase_idx != 3);
      sent = 0;
      while (sent < REQUESTS_PER_PHASE) begin
        random_polygon(sent);
        // Now and then the sender waits for the receiver to catch up fully.
        if ($urandom_range(0, 99) < 4) drain();
      end
      drain();

      if (phase_idx == 2) begin
        // A long outline bouncing between opposite corners: each edge is
        // the longest possible, so the running sum grows to a large value.
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        write_radius(24'($urandom));
        for (vertex_idx = 0; vertex_idx < LONG_OUTLINE_VERTICES; vertex_idx++) begin
          if (vertex_idx % 2 == 0)
            push_vertex(C_MIN, C_MIN, 1'b0);
          else
            push_vertex(C_MAX, C_MAX, vertex_idx == LONG_OUTLINE_VERTICES - 1);
        end
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("closed_polygon_perimeter_tb: PASS");
    end else begin
      $display("closed_polygon_perimeter_tb: FAIL");
    end
    $finish;
  end

endmodule
